// ===== src/fdsa_pkg.sv =====
// fdsa_pkg: shared types and constants of the forth data stack unit
`default_nettype none

package fdsa_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_DATA_WIDTH  = 32;

    // word codes
    localparam logic [4:0] CMD_DOT    = 5'd0;
    localparam logic [4:0] CMD_CR     = 5'd1;
    localparam logic [4:0] CMD_LIT    = 5'd2;
    localparam logic [4:0] CMD_DUP    = 5'd3;
    localparam logic [4:0] CMD_DROP   = 5'd4;
    localparam logic [4:0] CMD_SWAP   = 5'd5;
    localparam logic [4:0] CMD_ROT    = 5'd6;
    localparam logic [4:0] CMD_NIP    = 5'd7;
    localparam logic [4:0] CMD_ADD    = 5'd8;
    localparam logic [4:0] CMD_SUB    = 5'd9;
    localparam logic [4:0] CMD_MUL    = 5'd10;
    localparam logic [4:0] CMD_DIV    = 5'd11;
    localparam logic [4:0] CMD_MOD    = 5'd12;
    localparam logic [4:0] CMD_ABS    = 5'd13;
    localparam logic [4:0] CMD_NEGATE = 5'd14;
    localparam logic [4:0] CMD_MIN    = 5'd15;
    localparam logic [4:0] CMD_MAX    = 5'd16;
    localparam logic [4:0] CMD_EQ     = 5'd17;
    localparam logic [4:0] CMD_LT     = 5'd18;
    localparam logic [4:0] CMD_GT     = 5'd19;

    // status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_UNDER   = 3'd1;
    localparam logic [2:0] STAT_OVER    = 3'd2;
    localparam logic [2:0] STAT_DIVZ    = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN = 3'd4;
    localparam logic [2:0] STAT_HALTED  = 3'd5;

    typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_op_t;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] literal_value;
    } cmd_word_t;

    typedef struct packed {
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               newline_out;
        logic signed [31:0] top_value;
        logic [6:0]         stack_depth;
        logic [2:0]         status;
    } result_word_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic write;
        logic commit;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic long_op;
        logic has_push;
        logic last_write;
        logic md_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/fdsa_chan_if.sv =====
// fdsa_chan_if: valid/ready channel carrying one word
`default_nettype none

interface fdsa_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/fdsa_muldiv.sv =====
// fdsa_muldiv: iterative shift-add multiplier and restoring divider
`default_nettype none

module fdsa_muldiv
    import fdsa_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire md_op_t                op,
    input  wire logic [DATA_WIDTH-1:0] a,
    input  wire logic [DATA_WIDTH-1:0] b,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      result
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg;
    logic [CW-1:0]         cnt_reg;
    md_op_t                op_reg;
    logic                  neg_q_reg;
    logic                  neg_r_reg;
    logic [DATA_WIDTH:0]   acc_reg;
    logic [DATA_WIDTH-1:0] sh_reg;
    logic [DATA_WIDTH-1:0] opd_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] res_reg;

    logic [DATA_WIDTH-1:0] ua;
    logic [DATA_WIDTH-1:0] ub;
    logic [DATA_WIDTH:0]   rs;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] sum;

    // magnitudes; the most negative value maps onto its own unsigned magnitude
    assign ua   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    assign ub   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
    assign rs   = {acc_reg[DATA_WIDTH-1:0], sh_reg[DATA_WIDTH-1]};
    assign diff = rs - {1'b0, opd_reg};
    assign sum  = acc_reg[DATA_WIDTH-1:0] + opd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            op_reg    <= MD_MUL;
            neg_q_reg <= 1'b0;
            neg_r_reg <= 1'b0;
            acc_reg   <= '0;
            sh_reg    <= '0;
            opd_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CW'(DATA_WIDTH);
                op_reg    <= op;
                acc_reg   <= '0;
                neg_q_reg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                neg_r_reg <= a[DATA_WIDTH-1];
                if (op == MD_MUL)
                begin
                    sh_reg  <= b;
                    opd_reg <= a;
                end
                else
                begin
                    sh_reg  <= ua;
                    opd_reg <= ub;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (op_reg == MD_MUL)
                    begin
                        if (sh_reg[0])
                        begin
                            acc_reg <= {1'b0, sum};
                        end
                        opd_reg <= opd_reg << 1;
                        sh_reg  <= sh_reg >> 1;
                    end
                    else if (!diff[DATA_WIDTH])
                    begin
                        acc_reg <= diff;
                        sh_reg  <= {sh_reg[DATA_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= rs;
                        sh_reg  <= {sh_reg[DATA_WIDTH-2:0], 1'b0};
                    end
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    case (op_reg)
                        MD_MUL:  res_reg <= acc_reg[DATA_WIDTH-1:0];
                        MD_DIV:  res_reg <= neg_q_reg ? (~sh_reg + 1'b1) : sh_reg;
                        default: res_reg <= neg_r_reg ? (~acc_reg[DATA_WIDTH-1:0] + 1'b1)
                                                      : acc_reg[DATA_WIDTH-1:0];
                    endcase
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== src/fdsa_ctrl.sv =====
// fdsa_ctrl: sequencer for one forth word at a time
`default_nettype none

module fdsa_ctrl
    import fdsa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_ctrl_t      ctrl
);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WAIT_MD, S_WRITE, S_DONE} state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (stat.long_op)
                    begin
                        state_reg <= S_WAIT_MD;
                    end
                    else if (stat.has_push)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_WAIT_MD:
                begin
                    if (stat.md_done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (stat.last_write)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        ctrl.exec   = (state_reg == S_EXEC);
        ctrl.write  = (state_reg == S_WRITE);
        ctrl.commit = (state_reg == S_DONE) && stat.out_free;
    end

endmodule

`default_nettype wire

// ===== src/fdsa_dp.sv =====
// fdsa_dp: stack memory, cached top, word decode and result register
`default_nettype none

module fdsa_dp
    import fdsa_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_load,
    input  wire cmd_word_t in_word,
    input  wire dp_ctrl_t  ctrl,
    output dp_stat_t       stat,
    output result_word_t   res_word,
    output logic           res_valid,
    input  wire logic      res_ready
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DW  = DATA_WIDTH;

    logic [DW-1:0]  mem [STACK_DEPTH];

    logic [4:0]     cmd_reg;
    logic [DW-1:0]  lit_reg;
    logic [SPW-1:0] sp_reg;
    logic [DW-1:0]  tos_reg;
    logic           halted_reg;
    logic [DW-1:0]  rd_a_reg;
    logic [DW-1:0]  rd_b_reg;

    logic [DW-1:0]  push_reg [3];
    logic [1:0]     nacc_reg;
    logic [1:0]     widx_reg;
    logic [SPW-1:0] base_reg;
    logic [SPW-1:0] new_sp_reg;
    logic [DW-1:0]  alt_top_reg;
    logic [2:0]     status_reg;
    logic           pvalid_reg;
    logic [DW-1:0]  pval_reg;
    logic           nl_reg;
    logic           halt_set_reg;

    result_word_t   res_reg;
    logic           res_valid_reg;

    logic [SPW-1:0] addr_a;
    logic [SPW-1:0] addr_b;
    logic [SPW-1:0] waddr;

    logic signed [DW-1:0] top_v;
    logic signed [DW-1:0] sec_v;
    logic signed [DW-1:0] thr_v;
    logic [1:0]     npop;
    logic [1:0]     npush;
    logic [DW-1:0]  p0;
    logic [DW-1:0]  p1;
    logic [DW-1:0]  p2;
    logic           is_print;
    logic           is_nl;
    logic           long_op;
    logic           divz;
    logic           unknown;
    md_op_t         md_op;
    logic [SPW-1:0] sp_after;
    logic [SPW-1:0] room;
    logic           under;
    logic           over;
    logic [1:0]     nacc;
    logic [2:0]     status_c;
    logic [DW-1:0]  alt_top;
    logic [DW-1:0]  commit_top;
    logic [1:0]     top_idx;

    logic           md_done;
    logic [DW-1:0]  md_result;

    assign addr_a = sp_reg - SPW'(2);
    assign addr_b = sp_reg - SPW'(3);
    assign waddr  = base_reg + SPW'(widx_reg);

    // second and third entries are read every cycle from the committed pointer
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[addr_a[AW-1:0]];
        rd_b_reg <= mem[addr_b[AW-1:0]];
        if (ctrl.write)
        begin
            mem[waddr[AW-1:0]] <= push_reg[widx_reg];
        end
    end

    always_comb
    begin
        top_v    = (sp_reg >= SPW'(1)) ? tos_reg  : '0;
        sec_v    = (sp_reg >= SPW'(2)) ? rd_a_reg : '0;
        thr_v    = (sp_reg >= SPW'(3)) ? rd_b_reg : '0;
        npop     = 2'd0;
        npush    = 2'd0;
        p0       = '0;
        p1       = '0;
        p2       = '0;
        is_print = 1'b0;
        is_nl    = 1'b0;
        long_op  = 1'b0;
        divz     = 1'b0;
        unknown  = 1'b0;
        md_op    = MD_MUL;
        if (!halted_reg)
        begin
            unique case (cmd_reg) inside
                CMD_DOT:
                begin
                    npop     = 2'd1;
                    is_print = 1'b1;
                end
                CMD_CR:   is_nl = 1'b1;
                CMD_LIT:
                begin
                    npush = 2'd1;
                    p0    = lit_reg;
                end
                CMD_DUP:
                begin
                    npop  = 2'd1;
                    npush = 2'd2;
                    p0    = top_v;
                    p1    = top_v;
                end
                CMD_DROP: npop = 2'd1;
                CMD_SWAP:
                begin
                    npop  = 2'd2;
                    npush = 2'd2;
                    p0    = top_v;
                    p1    = sec_v;
                end
                CMD_ROT:
                begin
                    npop  = 2'd3;
                    npush = 2'd3;
                    p0    = sec_v;
                    p1    = top_v;
                    p2    = thr_v;
                end
                CMD_NIP:
                begin
                    npop  = 2'd2;
                    npush = 2'd1;
                    p0    = top_v;
                end
                CMD_ABS:
                begin
                    npop  = 2'd1;
                    npush = 2'd1;
                    p0    = top_v[DW-1] ? (~top_v + 1'b1) : top_v;
                end
                CMD_NEGATE:
                begin
                    npop  = 2'd1;
                    npush = 2'd1;
                    p0    = ~top_v + 1'b1;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
                CMD_MIN, CMD_MAX, CMD_EQ, CMD_LT, CMD_GT:
                begin
                    npop  = 2'd2;
                    npush = 2'd1;
                    case (cmd_reg) inside
                        CMD_ADD: p0 = sec_v + top_v;
                        CMD_SUB: p0 = sec_v - top_v;
                        CMD_MUL:
                        begin
                            long_op = 1'b1;
                            md_op   = MD_MUL;
                        end
                        CMD_DIV, CMD_MOD:
                        begin
                            md_op = (cmd_reg == CMD_DIV) ? MD_DIV : MD_MOD;
                            if (top_v == '0)
                            begin
                                divz = 1'b1;
                            end
                            else
                            begin
                                long_op = 1'b1;
                            end
                        end
                        CMD_MIN: p0 = (top_v < sec_v) ? top_v : sec_v;
                        CMD_MAX: p0 = (sec_v < top_v) ? top_v : sec_v;
                        CMD_EQ:  p0 = (sec_v == top_v) ? '1 : '0;
                        CMD_LT:  p0 = (sec_v < top_v) ? '1 : '0;
                        default: p0 = (sec_v > top_v) ? '1 : '0;
                    endcase
                end
                default: unknown = 1'b1;
            endcase
        end

        // pops from an empty stack leave it empty, late pushes onto a full one drop
        sp_after = (SPW'(npop) > sp_reg) ? '0 : (sp_reg - SPW'(npop));
        room     = SPW'(STACK_DEPTH) - sp_after;
        under    = SPW'(npop) > sp_reg;
        over     = SPW'(npush) > room;
        nacc     = over ? room[1:0] : npush;

        if (halted_reg)
        begin
            status_c = STAT_HALTED;
        end
        else if (unknown)
        begin
            status_c = STAT_UNKNOWN;
        end
        else if (under)
        begin
            status_c = STAT_UNDER;
        end
        else if (over)
        begin
            status_c = STAT_OVER;
        end
        else if (divz)
        begin
            status_c = STAT_DIVZ;
        end
        else
        begin
            status_c = STAT_OK;
        end

        if (sp_after == '0)
        begin
            alt_top = '0;
        end
        else if (npop == 2'd0)
        begin
            alt_top = tos_reg;
        end
        else
        begin
            alt_top = sec_v;
        end

        top_idx    = nacc_reg - 2'd1;
        commit_top = (nacc_reg != 2'd0) ? push_reg[top_idx] : alt_top_reg;
    end

    fdsa_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.exec && long_op),
        .op     (md_op),
        .a      (sec_v),
        .b      (top_v),
        .done   (md_done),
        .result (md_result)
    );

    // item payload and step results
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            cmd_reg <= in_word.command;
            lit_reg <= DW'(in_word.literal_value);
        end
        if (ctrl.exec)
        begin
            push_reg[0]  <= p0;
            push_reg[1]  <= p1;
            push_reg[2]  <= p2;
            base_reg     <= sp_after;
            new_sp_reg   <= sp_after + SPW'(nacc);
            alt_top_reg  <= alt_top;
            status_reg   <= status_c;
            pvalid_reg   <= is_print;
            pval_reg     <= is_print ? top_v : '0;
            nl_reg       <= is_nl;
            halt_set_reg <= unknown;
        end
        else if (md_done)
        begin
            push_reg[0] <= md_result;
        end
        if (ctrl.commit)
        begin
            res_reg.print_valid <= pvalid_reg;
            res_reg.print_value <= 32'(signed'(pval_reg));
            res_reg.newline_out <= nl_reg;
            res_reg.top_value   <= 32'(signed'(commit_top));
            res_reg.stack_depth <= 7'(new_sp_reg);
            res_reg.status      <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            tos_reg       <= '0;
            halted_reg    <= 1'b0;
            nacc_reg      <= 2'd0;
            widx_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                nacc_reg <= nacc;
                widx_reg <= 2'd0;
            end
            else if (ctrl.write)
            begin
                widx_reg <= widx_reg + 2'd1;
            end
            if (ctrl.commit)
            begin
                sp_reg        <= new_sp_reg;
                tos_reg       <= commit_top;
                halted_reg    <= halted_reg | halt_set_reg;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.long_op    = long_op;
        stat.has_push   = (nacc != 2'd0);
        stat.last_write = (widx_reg + 2'd1) == nacc_reg;
        stat.md_done    = md_done;
        stat.out_free   = !res_valid_reg || res_ready;
    end

    assign res_word  = res_reg;
    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> $stable(res_reg))
        else $error("pending result overwritten");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.write |-> (waddr < SPW'(STACK_DEPTH)))
        else $error("stack write beyond depth");
`endif

endmodule

`default_nettype wire

// ===== src/forth_data_stack_alu_top.sv =====
// forth_data_stack_alu_top: forth data stack execution unit, top level
//
//  channel   role    word           fields
//  cmd_ch    sink    cmd_word_t     command, literal_value
//  res_ch    source  result_word_t  print_valid .. status
//
//  one word at a time: accept, decode, push writes (one per pushed value), commit
//  mul, and div and mod with a nonzero divisor, wait for the result of the shared
//  iterative multiply/divide unit
//  reset clears pointer, halt flag and result valid; the stack memory is not cleared
//  a result waits in the output register while the next word is decoded; a stall
//  there holds the commit only
`default_nettype none

module forth_data_stack_alu_top
    import fdsa_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    fdsa_chan_if.sink   cmd_ch,
    fdsa_chan_if.source res_ch
);

    dp_ctrl_t     ctrl;
    dp_stat_t     stat;
    logic         in_ready;
    result_word_t res_word;
    logic         res_valid;

    fdsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    fdsa_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_load   (cmd_ch.valid && in_ready),
        .in_word   (cmd_ch.payload),
        .ctrl      (ctrl),
        .stat      (stat),
        .res_word  (res_word),
        .res_valid (res_valid),
        .res_ready (res_ch.ready)
    );

    assign cmd_ch.ready   = in_ready;
    assign res_ch.valid   = res_valid;
    assign res_ch.payload = res_word;

endmodule

`default_nettype wire

// ===== tb/tb_forth_data_stack_alu_top.sv =====
// testbench for the forth data stack execution unit: predicts each result and checks it
`timescale 1ns / 1ps

module tb_forth_data_stack_alu_top;
    import fdsa_pkg::*;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 20000;

    class stack_scoreboard;
        logic [31:0]  stack_mem [DEPTH];
        int           sp;
        bit           halted;
        result_word_t pending [$];
        int           mismatches;
        bit           under_f, over_f;

        function new();
            sp = 0;
            halted = 0;
            mismatches = 0;
        endfunction

        function logic [31:0] pop_word();
            if (sp == 0)
            begin
                under_f = 1;
                return 32'd0;
            end
            sp--;
            return stack_mem[sp];
        endfunction

        function void push_word(logic [31:0] v);
            if (sp >= DEPTH)
            begin
                over_f = 1;
                return;
            end
            stack_mem[sp] = v;
            sp++;
        endfunction

        function void note_command(cmd_word_t w);
            result_word_t r;
            logic signed [31:0] a, b, c;
            logic [31:0] ua, ub, q;
            bit dz;
            r = '0;
            dz = 0;
            under_f = 0;
            over_f = 0;
            if (halted)
                r.status = STAT_HALTED;
            else if (w.command > CMD_GT)
            begin
                halted = 1;
                r.status = STAT_UNKNOWN;
            end
            else
            begin
                case (w.command)
                    CMD_DOT:
                    begin
                        r.print_value = pop_word();
                        r.print_valid = 1;
                    end
                    CMD_CR: r.newline_out = 1;
                    CMD_LIT: push_word(w.literal_value);
                    CMD_DUP:
                    begin
                        a = pop_word();
                        push_word(a);
                        push_word(a);
                    end
                    CMD_DROP: a = pop_word();
                    CMD_SWAP:
                    begin
                        b = pop_word();
                        a = pop_word();
                        push_word(b);
                        push_word(a);
                    end
                    CMD_ROT:
                    begin
                        c = pop_word();
                        b = pop_word();
                        a = pop_word();
                        push_word(b);
                        push_word(c);
                        push_word(a);
                    end
                    CMD_NIP:
                    begin
                        b = pop_word();
                        a = pop_word();
                        push_word(b);
                    end
                    CMD_ABS:
                    begin
                        a = pop_word();
                        push_word(a < 0 ? -a : a);
                    end
                    CMD_NEGATE:
                    begin
                        a = pop_word();
                        push_word(-a);
                    end
                    default:
                    begin
                        b = pop_word();
                        a = pop_word();
                        case (w.command)
                            CMD_ADD: push_word(a + b);
                            CMD_SUB: push_word(a - b);
                            CMD_MUL: push_word(a * b);
                            CMD_DIV, CMD_MOD:
                            begin
                                if (b == 0)
                                begin
                                    dz = 1;
                                    push_word(32'd0);
                                end
                                else
                                begin
                                    ua = a < 0 ? -a : a;
                                    ub = b < 0 ? -b : b;
                                    if (w.command == CMD_DIV)
                                    begin
                                        q = ua / ub;
                                        push_word(((a < 0) != (b < 0)) ? -q : q);
                                    end
                                    else
                                    begin
                                        q = ua % ub;
                                        push_word(a < 0 ? -q : q);
                                    end
                                end
                            end
                            CMD_MIN: push_word(b < a ? b : a);
                            CMD_MAX: push_word(a < b ? b : a);
                            CMD_EQ: push_word(a == b ? 32'hFFFF_FFFF : 32'd0);
                            CMD_LT: push_word(a < b ? 32'hFFFF_FFFF : 32'd0);
                            default: push_word(b < a ? 32'hFFFF_FFFF : 32'd0);
                        endcase
                    end
                endcase
                if (under_f)
                    r.status = STAT_UNDER;
                else if (over_f)
                    r.status = STAT_OVER;
                else if (dz)
                    r.status = STAT_DIVZ;
            end
            r.top_value = sp != 0 ? stack_mem[sp - 1] : 32'd0;
            r.stack_depth = sp[6:0];
            pending = {pending, r};
        endfunction

        function void check_result(result_word_t got);
            result_word_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", exp_r, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    stack_scoreboard sb;
    int  idle_cycles;
    bit  long_hold;
    bit  stim_done;

    fdsa_chan_if #(.payload_t(cmd_word_t))    cmd_ch ();
    fdsa_chan_if #(.payload_t(result_word_t)) res_ch ();

    forth_data_stack_alu_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch.sink),
        .res_ch (res_ch.source)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
    begin
        cmd_ch.valid = 0;
        cmd_ch.payload = '0;
        res_ch.ready = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    // receiver: own stall pattern, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 0;
        else if (long_hold)
            res_ch.ready <= 0;
        else
            res_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.payload);
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.note_command(cmd_ch.payload);
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("forth_data_stack_alu_top regression: fail");
            $finish;
        end
    end

    task automatic send_word(logic [4:0] op, logic [31:0] v);
        cmd_ch.valid <= 1;
        cmd_ch.payload <= '{command: op, literal_value: v};
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        cmd_ch.valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drain();
        cmd_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic random_run(int count);
        int burst;
        int i;
        logic [4:0] op;
        burst = 0;
        for (i = 0; i < count; i++)
        begin
            // keep the stack mostly shallow, with one climb to full halfway through the run
            if (sb.sp < 3 || $urandom_range(0, 3) == 0)
                op = CMD_LIT;
            else
                op = 5'($urandom_range(CMD_DOT, CMD_GT));
            if (i == count / 2)
                repeat (70) send_word(CMD_LIT, $urandom);
            send_word(op, rand_value());
            if (burst == 0)
            begin
                if ($urandom_range(0, 1))
                    pause_sender();
                burst = $urandom_range(1, 20);
            end
            burst--;
        end
    endtask

    initial
    begin
        int k;
        long_hold = 0;
        idle_cycles = 0;
        sb = new();
        @(posedge rst_n);
        @(posedge clk);
        // directed: underflow on an empty stack, then the corner values
        send_word(CMD_DOT, 32'd0);
        send_word(CMD_ADD, 32'd0);
        send_word(CMD_CR, 32'd0);
        send_word(CMD_LIT, 32'h8000_0000);
        send_word(CMD_LIT, 32'hFFFF_FFFF);
        send_word(CMD_DIV, 32'd0);
        send_word(CMD_DUP, 32'd0);
        send_word(CMD_ABS, 32'd0);
        send_word(CMD_NEGATE, 32'd0);
        send_word(CMD_LIT, 32'h8000_0000);
        send_word(CMD_LIT, 32'hFFFF_FFFF);
        send_word(CMD_MOD, 32'd0);
        send_word(CMD_LIT, 32'd0);
        send_word(CMD_DIV, 32'd0);
        send_word(CMD_LIT, 32'h7FFF_FFFF);
        send_word(CMD_LIT, 32'd0);
        send_word(CMD_MOD, 32'd0);
        send_word(CMD_LIT, 32'hFFFF_FFF9);
        send_word(CMD_ROT, 32'd0);
        send_word(CMD_SWAP, 32'd0);
        send_word(CMD_NIP, 32'd0);
        for (k = CMD_SUB; k <= CMD_GT; k++)
        begin
            send_word(CMD_LIT, $urandom);
            send_word(CMD_LIT, $urandom_range(0, 5));
            send_word(k[4:0], 32'd0);
        end
        // receiver holds off for a counted stretch while words keep coming
        fork
            begin
                long_hold = 1;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
        join_none
        for (k = 0; k < 70; k++)
            send_word(CMD_LIT, $urandom);
        cmd_ch.valid <= 0;
        wait (!long_hold);
        wait_drain();
        random_run(380);
        // halt and stay halted
        send_word(5'(20 + $urandom_range(0, 11)), $urandom);
        send_word(CMD_LIT, $urandom);
        send_word(CMD_DOT, 32'd0);
        send_word(5'd31, 32'd0);
        wait_drain();
        if (sb.mismatches == 0)
            $display("forth_data_stack_alu_top regression: pass");
        else
            $display("forth_data_stack_alu_top regression: fail");
        $finish;
    end
endmodule
